// ----- sv/sxfb_pkg.sv -----
// Package for the XOR sprite framebuffer.
// Holds the screen geometry, derived widths and request codes.
// No dependencies.
`default_nettype none

package sxfb_pkg;

  localparam int SCREEN_ROWS = 32;
  localparam int SCREEN_COLS = 64;
  localparam int SPRITE_BITS = 8;

  localparam int ROW_W     = 64;
  localparam int PIX_AW    = 6;
  localparam int ROW_AW    = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
  localparam int COL_AW    = $clog2(SCREEN_COLS);
  localparam int BIT_AW    = $clog2(SPRITE_BITS);
  localparam int ACC_W     = 9;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_DRAW  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

endpackage

`default_nettype wire

// ----- sv/sxfb_if.sv -----
// Channel interfaces for the XOR sprite framebuffer: request and result.
// Depends on nothing but the valid/ready convention.
`default_nettype none

interface sxfb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] x_pos;
  logic [7:0] y_pos;
  logic [3:0] row_offset;
  logic [7:0] sprite_byte;
  logic       last_row;

  modport source (output valid, req_type, x_pos, y_pos, row_offset, sprite_byte, last_row,
                  input ready);
  modport sink (input valid, req_type, x_pos, y_pos, row_offset, sprite_byte, last_row,
                output ready);
endinterface

interface sxfb_res_if;
  logic        valid;
  logic        ready;
  logic        collision;
  logic [63:0] row_data;
  logic        sprite_done;

  modport source (output valid, collision, row_data, sprite_done, input ready);
  modport sink (input valid, collision, row_data, sprite_done, output ready);
endinterface

`default_nettype wire

// ----- sv/sxfb_ram.sv -----
// Generic single-port RAM, one write or read per cycle, registered read.
// No dependencies.
`default_nettype none

module sxfb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- sv/sprite_xor_framebuffer_top.sv -----
// Top level of the XOR sprite framebuffer: sequencer, bit toggle unit,
// row buffer. Depends on sxfb_pkg, sxfb_if.sv and sxfb_ram.
//
// Usage: requests arrive on req (valid/ready), one result per request leaves
// on res (valid/ready). Request types: clear, draw one sprite row, read row.
// One request is worked on at a time; req.ready is high only while idle.
// A draw masks (y+offset) and x down to the screen size (both powers of two),
// reads the row, toggles the 8 sprite bits one per cycle in a row buffer and
// writes the row back. A read masks y alone and returns the stored row.
// Pixel rows live in a single-port RAM; a flop per row marks it as written,
// so a clear only drops those flags, and unwritten rows read as zero.
// The finished result sits in an output register; the next request is taken
// while it waits, but the block holds its following result until res.ready.
// Reset (rst, synchronous) blanks the screen and clears the collision flag.
`default_nettype none

module sprite_xor_framebuffer_top (
  input wire logic   clk,
  input wire logic   rst,
  sxfb_req_if.sink   req,
  sxfb_res_if.source res
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b00_0001,
    ST_BITS    = 6'b00_0010,
    ST_WRITE   = 6'b00_0100,
    ST_RD_WAIT = 6'b00_1000,
    ST_RD_CAP  = 6'b01_0000,
    ST_DONE    = 6'b10_0000
  } state_t;

  state_t                                 state;
  logic [sxfb_pkg::ROW_AW-1:0]            row_idx;
  logic [sxfb_pkg::COL_AW-1:0]            col;
  logic [sxfb_pkg::BIT_AW-1:0]            bit_cnt;
  logic [sxfb_pkg::ROW_W-1:0]             row_buf;
  logic                                   hit;
  logic                                   is_draw;
  logic                                   first_row;
  logic [7:0]                             byte_q;
  logic                                   last_q;
  logic                                   coll_flag;
  logic [sxfb_pkg::SCREEN_ROWS-1:0]       row_valid;
  logic                                   res_coll;
  logic [sxfb_pkg::ROW_W-1:0]             res_row;
  logic                                   res_done;
  logic                                   out_valid;
  logic                                   out_coll;
  logic [sxfb_pkg::ROW_W-1:0]             out_row;
  logic                                   out_done;

  logic [sxfb_pkg::ROW_W-1:0]             rd_data;
  logic [sxfb_pkg::ROW_W-1:0]             rd_row;
  logic                                   ram_we;
  logic [sxfb_pkg::ACC_W-1:0]             row_sum;
  logic [sxfb_pkg::ROW_AW-1:0]            row_sel;
  logic [sxfb_pkg::COL_AW-1:0]            col_sel;
  logic [sxfb_pkg::PIX_AW-1:0]            pix;
  logic                                   sbit;
  logic                                   accept;
  logic                                   out_free;
  logic                                   coll_next;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign out_free = !out_valid || res.ready;

  // screen sizes are powers of two: the wrap is a mask
  assign row_sum = sxfb_pkg::ACC_W'(req.y_pos)
                 + ((req.req_type == sxfb_pkg::REQ_DRAW) ? sxfb_pkg::ACC_W'(req.row_offset)
                                                         : '0);
  assign row_sel = sxfb_pkg::ROW_AW'(row_sum % sxfb_pkg::ACC_W'(sxfb_pkg::SCREEN_ROWS));
  assign col_sel = sxfb_pkg::COL_AW'(req.x_pos % 8'(sxfb_pkg::SCREEN_COLS));

  assign rd_row = row_valid[row_idx] ? rd_data : '0;
  assign sbit   = byte_q[sxfb_pkg::BIT_AW'(sxfb_pkg::SPRITE_BITS - 1) - bit_cnt];
  assign pix    = sxfb_pkg::PIX_AW'(sxfb_pkg::ROW_W - 1) - sxfb_pkg::PIX_AW'(col);
  assign coll_next = (first_row ? 1'b0 : coll_flag) | hit;
  assign ram_we = (state == ST_WRITE);

  sxfb_ram #(
    .WIDTH (sxfb_pkg::ROW_W),
    .DEPTH (sxfb_pkg::SCREEN_ROWS),
    .AW    (sxfb_pkg::ROW_AW)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .addr  (row_idx),
    .wdata (row_buf),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      coll_flag <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            byte_q    <= req.sprite_byte;
            last_q    <= req.last_row;
            first_row <= (req.row_offset == 4'd0);
            is_draw   <= (req.req_type == sxfb_pkg::REQ_DRAW);
            row_idx   <= row_sel;
            col       <= col_sel;
            res_coll  <= 1'b0;
            res_row   <= '0;
            res_done  <= 1'b0;
            case (req.req_type)
              sxfb_pkg::REQ_CLEAR: begin
                row_valid <= '0;
                state     <= ST_DONE;
              end
              sxfb_pkg::REQ_DRAW, sxfb_pkg::REQ_READ: begin
                state <= ST_RD_WAIT;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_BITS: begin
          if (sbit) begin
            hit          <= hit | row_buf[pix];
            row_buf[pix] <= ~row_buf[pix];
          end
          col     <= (col == sxfb_pkg::COL_AW'(sxfb_pkg::SCREEN_COLS - 1)) ? '0 : col + 1'b1;
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == sxfb_pkg::BIT_AW'(sxfb_pkg::SPRITE_BITS - 1)) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          row_valid[row_idx] <= 1'b1;
          coll_flag          <= coll_next;
          res_coll           <= coll_next;
          res_done           <= last_q;
          state              <= ST_DONE;
        end
        ST_RD_WAIT: begin
          state <= ST_RD_CAP;
        end
        ST_RD_CAP: begin
          if (is_draw) begin
            row_buf <= rd_row;
            hit     <= 1'b0;
            bit_cnt <= '0;
            state   <= ST_BITS;
          end else begin
            res_row <= rd_row;
            state   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
        out_coll  <= res_coll;
        out_row   <= res_row;
        out_done  <= res_done;
      end
    end
  end

  assign res.valid       = out_valid;
  assign res.collision   = out_coll;
  assign res.row_data    = out_row;
  assign res.sprite_done = out_done;

endmodule

`default_nettype wire

// ----- tb/sprite_xor_framebuffer_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench for sprite_xor_framebuffer_top: directed and random clear, draw and read beats,
// checked against a behavioural framebuffer held in a small scoreboard class.
// Depends on sxfb_pkg, sxfb_if.sv and the RTL top level.
module sprite_xor_framebuffer_top_tb;

  localparam int ITEMS       = 1700;
  localparam int CYCLE_LIMIT = 800000;
  localparam int TAIL_CYCLES = 40;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [3:0] off;
    logic [7:0] bits;
    logic       last;
  } fb_req_t;

  typedef struct packed {
    logic        collision;
    logic [63:0] row_data;
    logic        sprite_done;
  } fb_res_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  class fb_scoreboard;
    logic [sxfb_pkg::ROW_W-1:0] pixels [sxfb_pkg::SCREEN_ROWS];
    logic                       hit_flag;
    fb_res_t                    due_q [$];
    int                         errors;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      hit_flag = 1'b0;
      errors   = 0;
    endfunction

    function void note_request(fb_req_t r);
      fb_res_t                    res;
      int                         tr;
      int                         col;
      logic [sxfb_pkg::ROW_W-1:0] line;
      logic [sxfb_pkg::ROW_W-1:0] mask;
      logic                       hit;
      res = '0;
      case (r.kind)
        sxfb_pkg::REQ_CLEAR: begin
          foreach (pixels[i]) pixels[i] = '0;
        end
        sxfb_pkg::REQ_DRAW: begin
          tr   = (int'(r.y) + int'(r.off)) % sxfb_pkg::SCREEN_ROWS;
          line = pixels[tr];
          hit  = 1'b0;
          for (int b = 0; b < sxfb_pkg::SPRITE_BITS; b++) begin
            if (r.bits[sxfb_pkg::SPRITE_BITS-1-b]) begin
              col  = (int'(r.x) + b) % sxfb_pkg::SCREEN_COLS;
              mask = '0;
              mask[sxfb_pkg::ROW_W-1-col] = 1'b1;
              if ((line & mask) != '0) hit = 1'b1;
              line ^= mask;
            end
          end
          pixels[tr] = line;
          if (r.off == 4'd0) hit_flag = 1'b0;
          if (hit) hit_flag = 1'b1;
          res.collision   = hit_flag;
          res.sprite_done = r.last;
        end
        sxfb_pkg::REQ_READ: begin
          res.row_data = pixels[int'(r.y) % sxfb_pkg::SCREEN_ROWS];
        end
        default: ;
      endcase
      due_q.push_back(res);
    endfunction

    function void check_result(fb_res_t got);
      fb_res_t want;
      if (due_q.size() == 0) begin
        $error("result beat with nothing outstanding: collision=%0b row_data=%h sprite_done=%0b",
               got.collision, got.row_data, got.sprite_done);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got.collision !== want.collision) begin
        $error("collision: expected %0b, got %0b", want.collision, got.collision);
        errors++;
      end
      if (got.row_data !== want.row_data) begin
        $error("row_data: expected %h, got %h", want.row_data, got.row_data);
        errors++;
      end
      if (got.sprite_done !== want.sprite_done) begin
        $error("sprite_done: expected %0b, got %0b", want.sprite_done, got.sprite_done);
        errors++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;

  sxfb_req_if req_ch ();
  sxfb_res_if res_ch ();

  sprite_xor_framebuffer_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  fb_scoreboard sb = new();

  int sent       = 0;
  int burst_left = 0;
  bit calm       = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sprite_xor_framebuffer_top test failed");
      $finish;
    end
  end

  function automatic fb_req_t mk(logic [1:0] kind, logic [7:0] x, logic [7:0] y,
                                 logic [3:0] off, logic [7:0] bits, logic last);
    fb_req_t r;
    r.kind = kind;
    r.x    = x;
    r.y    = y;
    r.off  = off;
    r.bits = bits;
    r.last = last;
    return r;
  endfunction

  task automatic send(input fb_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = calm ? 64 : $urandom_range(1, 12);
      gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= r.kind;
    req_ch.x_pos       <= r.x;
    req_ch.y_pos       <= r.y;
    req_ch.row_offset  <= r.off;
    req_ch.sprite_byte <= r.bits;
    req_ch.last_row    <= r.last;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(r);
    sent++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] sprite_bits();
    return ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom);
  endfunction

  task automatic send_sprite(input logic [7:0] x, input logic [7:0] y, input int n);
    for (int off = 0; off < n; off++)
      send(mk(sxfb_pkg::REQ_DRAW, x, y, 4'(off), sprite_bits(), off == n - 1));
  endtask

  // result side: checks beats and stalls on its own schedule
  initial begin
    int       rx_cycle;
    int       hold_left;
    rx_mode_t mode;
    logic     nxt;
    fb_res_t  got;
    rx_cycle  = 0;
    hold_left = 0;
    mode      = RX_OPEN;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got.collision   = res_ch.collision;
        got.row_data    = res_ch.row_data;
        got.sprite_done = res_ch.sprite_done;
        sb.check_result(got);
      end
      rx_cycle++;
      if (rx_cycle % 256 == 0) mode = rx_mode_t'($urandom_range(0, 3));
      if (rx_cycle == 4000 || rx_cycle == 45000) hold_left = 500;
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else begin
        case (mode)
          RX_OPEN:     nxt = 1'b1;
          RX_COIN:     nxt = 1'($urandom_range(0, 1));
          RX_PERIODIC: nxt = (rx_cycle % 5) != 0;
          default:     nxt = ($urandom_range(0, 4) == 0);
        endcase
      end
      res_ch.ready <= nxt;
    end
  end

  initial begin
    bit          drained_mid;
    int          pick;
    int          n;
    logic [7:0]  sx;
    logic [7:0]  sy;
    drained_mid = 1'b0;
    sx = 8'd0;
    sy = 8'd0;
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= sxfb_pkg::REQ_CLEAR;
    req_ch.x_pos       <= '0;
    req_ch.y_pos       <= '0;
    req_ch.row_offset  <= '0;
    req_ch.sprite_byte <= '0;
    req_ch.last_row    <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send(mk(sxfb_pkg::REQ_CLEAR, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0));
    send(mk(sxfb_pkg::REQ_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF, 1'b0));
    send(mk(sxfb_pkg::REQ_DRAW, 8'd0, 8'd31, 4'd1, 8'hFF, 1'b1));
    send(mk(sxfb_pkg::REQ_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0));
    send(mk(sxfb_pkg::REQ_DRAW, 8'd60, 8'd5, 4'd0, 8'hFF, 1'b1));
    send(mk(sxfb_pkg::REQ_READ, 8'd0, 8'd5, 4'd0, 8'h00, 1'b0));
    send(mk(sxfb_pkg::REQ_DRAW, 8'd255, 8'd255, 4'd15, 8'h81, 1'b1));
    send(mk(sxfb_pkg::REQ_READ, 8'd0, 8'd46, 4'd0, 8'h00, 1'b0));
    send(mk(sxfb_pkg::REQ_DRAW, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0));
    send(mk(sxfb_pkg::REQ_DRAW, 8'd3, 8'd3, 4'd0, 8'h3C, 1'b0));
    send(mk(sxfb_pkg::REQ_DRAW, 8'd3, 8'd2, 4'd1, 8'h18, 1'b0));
    send(mk(sxfb_pkg::REQ_DRAW, 8'd3, 8'd3, 4'd2, 8'h00, 1'b1));
    // continued without a first row: flag carries over
    send(mk(sxfb_pkg::REQ_DRAW, 8'd3, 8'd3, 4'd5, 8'h00, 1'b1));
    send(mk(sxfb_pkg::REQ_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1));
    send(mk(sxfb_pkg::REQ_DRAW, 8'd3, 8'd3, 4'd1, 8'h00, 1'b1));
    send(mk(REQ_SPARE, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1));
    send(mk(sxfb_pkg::REQ_READ, 8'hFF, 8'd20, 4'hF, 8'hFF, 1'b1));
    send(mk(sxfb_pkg::REQ_DRAW, 8'd255, 8'd255, 4'd15, 8'hFF, 1'b1));
    send(mk(sxfb_pkg::REQ_READ, 8'd0, 8'd255, 4'd0, 8'h00, 1'b0));
    send(mk(sxfb_pkg::REQ_READ, 8'd0, 8'd14, 4'd0, 8'h00, 1'b0));
    send(mk(sxfb_pkg::REQ_CLEAR, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0));
    send(mk(sxfb_pkg::REQ_READ, 8'd0, 8'd14, 4'd0, 8'h00, 1'b0));
    drain();

    while (sent < ITEMS) begin
      if (sent >= 800 && !drained_mid) begin
        drain();
        drained_mid = 1'b1;
      end
      calm = (sent >= 1100 && sent < 1250);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send(mk(2'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                8'($urandom), 1'($urandom)));
      end else if (pick < 14) begin
        send(mk(sxfb_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom),
                1'($urandom)));
      end else if (pick < 34) begin
        send(mk(sxfb_pkg::REQ_READ, 8'($urandom),
                ($urandom_range(0, 1) == 0) ? sy : 8'($urandom),
                4'($urandom), 8'($urandom), 1'($urandom)));
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          sx = 8'($urandom);
          sy = 8'($urandom);
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
        send_sprite(sx, sy, n);
      end
    end
    req_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("sprite_xor_framebuffer_top test passed");
    else
      $display("sprite_xor_framebuffer_top test failed");
    $finish;
  end

endmodule
